// ===== rtl/tac_pkg.sv =====
// Package for the transaction allow-list checker: word types, codes and sizes.
package tac_pkg;

    localparam int CHAIN_SLOTS     = 16;
    localparam int RECIPIENT_SLOTS = 16;
    localparam int TOKEN_SLOTS     = 16;
    localparam int CONTRACT_SLOTS  = 16;

    localparam int SLOT_MAX_A = (CHAIN_SLOTS > RECIPIENT_SLOTS) ? CHAIN_SLOTS : RECIPIENT_SLOTS;
    localparam int SLOT_MAX_B = (TOKEN_SLOTS > CONTRACT_SLOTS) ? TOKEN_SLOTS : CONTRACT_SLOTS;
    localparam int SLOT_MAX   = (SLOT_MAX_A > SLOT_MAX_B) ? SLOT_MAX_A : SLOT_MAX_B;

    // scan counter holds 0..slot count
    localparam int N_W   = $clog2(SLOT_MAX + 1);
    localparam int IDX_X = (N_W > 4) ? N_W : 4;
    localparam int CNT_X = (N_W > 5) ? N_W : 5;

    localparam int CHAIN_AW     = (CHAIN_SLOTS > 1) ? $clog2(CHAIN_SLOTS) : 1;
    localparam int RECIPIENT_AW = (RECIPIENT_SLOTS > 1) ? $clog2(RECIPIENT_SLOTS) : 1;
    localparam int TOKEN_AW     = (TOKEN_SLOTS > 1) ? $clog2(TOKEN_SLOTS) : 1;
    localparam int CONTRACT_AW  = (CONTRACT_SLOTS > 1) ? $clog2(CONTRACT_SLOTS) : 1;

    localparam int CHAIN_W = 32;
    localparam int ADDR_W  = 160;

    localparam logic [31:0] XFER_SELECTOR = 32'ha905_9cbb;
    localparam logic [15:0] SEL_MIN_LEN   = 16'd4;
    localparam logic [15:0] EMBED_MIN_LEN = 16'd36;

    localparam logic [1:0] CFG_CHAIN     = 2'd0;
    localparam logic [1:0] CFG_RECIPIENT = 2'd1;
    localparam logic [1:0] CFG_TOKEN     = 2'd2;
    localparam logic [1:0] CFG_CONTRACT  = 2'd3;

    localparam logic [1:0] LST_CHAIN     = 2'd0;
    localparam logic [1:0] LST_RECIPIENT = 2'd1;
    localparam logic [1:0] LST_TOKEN     = 2'd2;
    localparam logic [1:0] LST_CONTRACT  = 2'd3;

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [2:0] REASON_NONE      = 3'd0;
    localparam logic [2:0] REASON_CHAIN     = 3'd1;
    localparam logic [2:0] REASON_RECIPIENT = 3'd2;
    localparam logic [2:0] REASON_TOKEN     = 3'd3;
    localparam logic [2:0] REASON_CONTRACT  = 3'd4;

    localparam logic [1:0] CLS_NATIVE   = 2'd0;
    localparam logic [1:0] CLS_TOKEN    = 2'd1;
    localparam logic [1:0] CLS_CONTRACT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_CHAIN,
        PH_RECIPIENT,
        PH_TOKEN,
        PH_EMBED,
        PH_CONTRACT
    } t_phase;

    typedef struct packed {
        logic        req_type;
        logic [31:0] chain_num;
        logic [31:0] addr_hi;
        logic [63:0] addr_mid;
        logic [63:0] addr_lo;
        logic [31:0] call_selector;
        logic [15:0] data_length;
        logic [31:0] embedded_hi;
        logic [63:0] embedded_mid;
        logic [63:0] embedded_lo;
        logic [1:0]  list_select;
        logic [3:0]  entry_index;
    } t_in_word;

    typedef struct packed {
        logic       allowed;
        logic [2:0] deny_reason;
        logic [1:0] tx_class;
    } t_out_word;

endpackage

// ===== rtl/tac_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module tac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/transaction_allowlist_check.sv =====
// Transaction allow-list checker: four entry RAMs scanned by one shared comparator.
//
// Input channel (i_in_valid / o_in_stall, word i_in_word): a word is taken when valid
// is high and stall low. A write word stores one list entry in its accept cycle and
// gives no result, so writes may follow back to back. A check word is classified,
// then its chain id, then the destination and, for a token transfer with data length
// of at least 36, the embedded recipient are compared against the lists one entry a
// cycle through a single 160-bit equality comparator fed from the entry RAMs. Each
// visited list is scanned up to its count clamped to the slot count; a match ends its
// scan early, a miss on its last entry denies, and a zero count passes it at once. One
// to three lists are visited, and the verdict then passes through ST_OUT into the
// output register. o_in_stall is high from a check's accept until its verdict enters
// the output register, so no new word is taken while a check is in progress.
// Output channel (o_out_valid / i_out_stall, word o_out_word): the result is held
// until taken. While it waits, new words are taken; a later check that finishes its
// scan waits, with o_in_stall high, until the register is free.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data) sets the four list counts; write
// it only while idle. Synchronous reset clears counts and control state; the entry
// RAMs are not cleared and hold nothing meaningful until written.
module transaction_allowlist_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tac_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tac_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [4:0]          i_cfg_data
);

    tac_pkg::t_state r_state, n_state;
    tac_pkg::t_phase r_phase, n_phase;

    logic [4:0] r_chain_cnt, r_recip_cnt, r_token_cnt, r_contract_cnt;

    logic [tac_pkg::N_W-1:0] r_idx, n_idx;
    logic                    r_dvalid, n_dvalid;
    logic                    r_dlast, n_dlast;

    logic [tac_pkg::CHAIN_W-1:0] r_chain, n_chain;
    logic [tac_pkg::ADDR_W-1:0]  r_dest, n_dest;
    logic [tac_pkg::ADDR_W-1:0]  r_emb, n_emb;
    logic                        r_len36, n_len36;
    tac_pkg::t_out_word          r_out, n_out;
    logic                        r_ovalid, n_ovalid;
    tac_pkg::t_out_word          r_oword, n_oword;

    logic                          w_accept, w_wr;
    logic [tac_pkg::IDX_X-1:0]     w_eidx;
    logic                          w_chain_we, w_recip_we, w_token_we, w_contract_we;
    logic [tac_pkg::CHAIN_W-1:0]   w_chain_rd;
    logic [tac_pkg::ADDR_W-1:0]    w_recip_rd, w_token_rd, w_contract_rd;
    logic [tac_pkg::ADDR_W-1:0]    w_dest_in, w_emb_in;
    logic [tac_pkg::ADDR_W-1:0]    w_cmp_a, w_cmp_b;
    logic                          w_match;
    logic [4:0]                    w_cnt_sel;
    logic [tac_pkg::CNT_X-1:0]     w_cnt_x, w_slots_x, w_n_x;
    logic [tac_pkg::N_W-1:0]       w_n;
    logic                          w_pass, w_fail;
    logic [1:0]                    w_cls;

    assign o_in_stall  = (r_state != tac_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_wr     = w_accept && (i_in_word.req_type == tac_pkg::REQ_WRITE);
    assign w_eidx   = tac_pkg::IDX_X'(i_in_word.entry_index);

    assign w_chain_we = w_wr && (i_in_word.list_select == tac_pkg::LST_CHAIN)
                        && (w_eidx < tac_pkg::IDX_X'(tac_pkg::CHAIN_SLOTS));
    assign w_recip_we = w_wr && (i_in_word.list_select == tac_pkg::LST_RECIPIENT)
                        && (w_eidx < tac_pkg::IDX_X'(tac_pkg::RECIPIENT_SLOTS));
    assign w_token_we = w_wr && (i_in_word.list_select == tac_pkg::LST_TOKEN)
                        && (w_eidx < tac_pkg::IDX_X'(tac_pkg::TOKEN_SLOTS));
    assign w_contract_we = w_wr && (i_in_word.list_select == tac_pkg::LST_CONTRACT)
                        && (w_eidx < tac_pkg::IDX_X'(tac_pkg::CONTRACT_SLOTS));

    assign w_dest_in = {i_in_word.addr_hi, i_in_word.addr_mid, i_in_word.addr_lo};
    assign w_emb_in  = {i_in_word.embedded_hi, i_in_word.embedded_mid,
                        i_in_word.embedded_lo};

    tac_ram #(.WIDTH(tac_pkg::CHAIN_W), .DEPTH(tac_pkg::CHAIN_SLOTS)) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (w_chain_we),
        .i_waddr (w_eidx[tac_pkg::CHAIN_AW-1:0]),
        .i_wdata (i_in_word.chain_num),
        .i_raddr (r_idx[tac_pkg::CHAIN_AW-1:0]),
        .o_rdata (w_chain_rd)
    );

    tac_ram #(.WIDTH(tac_pkg::ADDR_W), .DEPTH(tac_pkg::RECIPIENT_SLOTS)) u_recip_ram (
        .i_clk   (i_clk),
        .i_we    (w_recip_we),
        .i_waddr (w_eidx[tac_pkg::RECIPIENT_AW-1:0]),
        .i_wdata (w_dest_in),
        .i_raddr (r_idx[tac_pkg::RECIPIENT_AW-1:0]),
        .o_rdata (w_recip_rd)
    );

    tac_ram #(.WIDTH(tac_pkg::ADDR_W), .DEPTH(tac_pkg::TOKEN_SLOTS)) u_token_ram (
        .i_clk   (i_clk),
        .i_we    (w_token_we),
        .i_waddr (w_eidx[tac_pkg::TOKEN_AW-1:0]),
        .i_wdata (w_dest_in),
        .i_raddr (r_idx[tac_pkg::TOKEN_AW-1:0]),
        .o_rdata (w_token_rd)
    );

    tac_ram #(.WIDTH(tac_pkg::ADDR_W), .DEPTH(tac_pkg::CONTRACT_SLOTS)) u_contract_ram (
        .i_clk   (i_clk),
        .i_we    (w_contract_we),
        .i_waddr (w_eidx[tac_pkg::CONTRACT_AW-1:0]),
        .i_wdata (w_dest_in),
        .i_raddr (r_idx[tac_pkg::CONTRACT_AW-1:0]),
        .o_rdata (w_contract_rd)
    );

    // count and operands of the list under scan
    always_comb begin
        case (r_phase)
            tac_pkg::PH_CHAIN: begin
                w_cnt_sel = r_chain_cnt;
                w_slots_x = tac_pkg::CNT_X'(tac_pkg::CHAIN_SLOTS);
                w_cmp_a   = tac_pkg::ADDR_W'(w_chain_rd);
                w_cmp_b   = tac_pkg::ADDR_W'(r_chain);
            end
            tac_pkg::PH_RECIPIENT: begin
                w_cnt_sel = r_recip_cnt;
                w_slots_x = tac_pkg::CNT_X'(tac_pkg::RECIPIENT_SLOTS);
                w_cmp_a   = w_recip_rd;
                w_cmp_b   = r_dest;
            end
            tac_pkg::PH_TOKEN: begin
                w_cnt_sel = r_token_cnt;
                w_slots_x = tac_pkg::CNT_X'(tac_pkg::TOKEN_SLOTS);
                w_cmp_a   = w_token_rd;
                w_cmp_b   = r_dest;
            end
            tac_pkg::PH_EMBED: begin
                w_cnt_sel = r_recip_cnt;
                w_slots_x = tac_pkg::CNT_X'(tac_pkg::RECIPIENT_SLOTS);
                w_cmp_a   = w_recip_rd;
                w_cmp_b   = r_emb;
            end
            default: begin
                w_cnt_sel = r_contract_cnt;
                w_slots_x = tac_pkg::CNT_X'(tac_pkg::CONTRACT_SLOTS);
                w_cmp_a   = w_contract_rd;
                w_cmp_b   = r_dest;
            end
        endcase
    end

    assign w_cnt_x = tac_pkg::CNT_X'(w_cnt_sel);
    assign w_n_x   = (w_cnt_x > w_slots_x) ? w_slots_x : w_cnt_x;
    assign w_n     = w_n_x[tac_pkg::N_W-1:0];
    assign w_match = (w_cmp_a == w_cmp_b);
    assign w_pass  = (w_n == '0) || (r_dvalid && w_match);
    assign w_fail  = !w_pass && r_dvalid && r_dlast;

    always_comb begin
        if (i_in_word.data_length == 16'd0) begin
            w_cls = tac_pkg::CLS_NATIVE;
        end else if ((i_in_word.data_length >= tac_pkg::SEL_MIN_LEN)
                     && (i_in_word.call_selector == tac_pkg::XFER_SELECTOR)) begin
            w_cls = tac_pkg::CLS_TOKEN;
        end else begin
            w_cls = tac_pkg::CLS_CONTRACT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_cnt    <= '0;
            r_recip_cnt    <= '0;
            r_token_cnt    <= '0;
            r_contract_cnt <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tac_pkg::CFG_CHAIN:     r_chain_cnt    <= i_cfg_data;
                tac_pkg::CFG_RECIPIENT: r_recip_cnt    <= i_cfg_data;
                tac_pkg::CFG_TOKEN:     r_token_cnt    <= i_cfg_data;
                tac_pkg::CFG_CONTRACT:  r_contract_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tac_pkg::ST_IDLE;
            r_phase  <= tac_pkg::PH_CHAIN;
            r_idx    <= '0;
            r_dvalid <= 1'b0;
            r_dlast  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_dvalid <= n_dvalid;
            r_dlast  <= n_dlast;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chain <= n_chain;
        r_dest  <= n_dest;
        r_emb   <= n_emb;
        r_len36 <= n_len36;
        r_out   <= n_out;
        r_oword <= n_oword;
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_dvalid = r_dvalid;
        n_dlast  = r_dlast;
        n_chain  = r_chain;
        n_dest   = r_dest;
        n_emb    = r_emb;
        n_len36  = r_len36;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_out_stall;
        n_oword  = r_oword;
        case (r_state)
            tac_pkg::ST_IDLE: begin
                if (w_accept && (i_in_word.req_type == tac_pkg::REQ_CHECK)) begin
                    n_state     = tac_pkg::ST_SCAN;
                    n_phase     = tac_pkg::PH_CHAIN;
                    n_idx       = '0;
                    n_dvalid    = 1'b0;
                    n_dlast     = 1'b0;
                    n_chain     = i_in_word.chain_num;
                    n_dest      = w_dest_in;
                    n_emb       = w_emb_in;
                    n_len36     = (i_in_word.data_length >= tac_pkg::EMBED_MIN_LEN);
                    n_out.allowed     = 1'b1;
                    n_out.deny_reason = tac_pkg::REASON_NONE;
                    n_out.tx_class    = w_cls;
                end
            end
            tac_pkg::ST_SCAN: begin
                // read pipeline: address this cycle, compare next
                n_dvalid = (r_idx < w_n);
                n_dlast  = (r_idx == (w_n - tac_pkg::N_W'(1)));
                if (r_idx < w_n) begin
                    n_idx = r_idx + tac_pkg::N_W'(1);
                end
                if (w_pass || w_fail) begin
                    n_idx    = '0;
                    n_dvalid = 1'b0;
                    n_dlast  = 1'b0;
                    n_state  = tac_pkg::ST_OUT;
                    case (r_phase)
                        tac_pkg::PH_CHAIN: begin
                            if (w_fail) begin
                                n_out.deny_reason = tac_pkg::REASON_CHAIN;
                            end else if (r_out.tx_class == tac_pkg::CLS_NATIVE) begin
                                n_state = tac_pkg::ST_SCAN;
                                n_phase = tac_pkg::PH_RECIPIENT;
                            end else if (r_out.tx_class == tac_pkg::CLS_TOKEN) begin
                                n_state = tac_pkg::ST_SCAN;
                                n_phase = tac_pkg::PH_TOKEN;
                            end else begin
                                n_state = tac_pkg::ST_SCAN;
                                n_phase = tac_pkg::PH_CONTRACT;
                            end
                        end
                        tac_pkg::PH_RECIPIENT, tac_pkg::PH_EMBED: begin
                            if (w_fail) begin
                                n_out.deny_reason = tac_pkg::REASON_RECIPIENT;
                            end
                        end
                        tac_pkg::PH_TOKEN: begin
                            if (w_fail) begin
                                n_out.deny_reason = tac_pkg::REASON_TOKEN;
                            end else begin
                                n_state = tac_pkg::ST_SCAN;
                                n_phase = r_len36 ? tac_pkg::PH_EMBED : tac_pkg::PH_CONTRACT;
                            end
                        end
                        default: begin
                            if (w_fail) begin
                                n_out.deny_reason = tac_pkg::REASON_CONTRACT;
                            end
                        end
                    endcase
                    if (w_fail) begin
                        n_out.allowed = 1'b0;
                    end
                end
            end
            tac_pkg::ST_OUT: begin
                // hand the verdict over once the output register is free
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_oword  = r_out;
                    n_state  = tac_pkg::ST_IDLE;
                    n_phase  = tac_pkg::PH_CHAIN;
                end
            end
            default: begin
                n_state = tac_pkg::ST_IDLE;
            end
        endcase
    end

    a_allow_no_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.allowed == (o_out_word.deny_reason
                                                == tac_pkg::REASON_NONE)))
        else $error("allowed flag disagrees with deny reason");

    a_token_reason_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.deny_reason == tac_pkg::REASON_TOKEN))
        |-> (o_out_word.tx_class == tac_pkg::CLS_TOKEN))
        else $error("token deny on a word not classed as token transfer");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tac_pkg::ST_SCAN) |-> (r_idx <= w_n))
        else $error("scan index ran past the list count");

    a_check_starts_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_word.req_type == tac_pkg::REQ_CHECK))
        |=> ((r_state == tac_pkg::ST_SCAN) && (r_phase == tac_pkg::PH_CHAIN)
             && !r_dvalid))
        else $error("check word did not start at the chain list");

endmodule
